@@ sv/hxf_pkg.sv @@
// Shared types, constants and character tables for the hex ASCII line framer.
`timescale 1ns / 1ps

package hxf_pkg;

    localparam int BYTES_PER_LINE_DEF = 64;
    localparam int QUEUE_DEPTH_DEF    = 4;
    localparam int LINE_CNT_W         = 7;
    localparam int HEAD_LEN           = 5;
    localparam int HEAD_IDX_W         = 3;

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    typedef struct packed {
        logic [7:0] data;
        logic       head;
        logic       tail;
    } hxf_cmd_t;

    typedef enum logic [2:0] {
        PH_BEGIN,
        PH_HEAD,
        PH_HI,
        PH_LO,
        PH_CR,
        PH_LF
    } hxf_phase_t;

    function automatic logic [7:0] head_char(input logic [HEAD_IDX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h54;
            3'd1:    c = 8'h58;
            3'd2:    c = 8'h44;
            3'd3:    c = 8'h41;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
            c = 8'h30 + {4'd0, nib};
        else
            c = 8'h57 + {4'd0, nib};
        return c;
    endfunction

endpackage

@@ sv/hxf_front.sv @@
// Front end: accepts input beats, tracks the line fill and classifies each byte.
`timescale 1ns / 1ps

module hxf_front
    import hxf_pkg::*;
#(
    parameter int BYTES_PER_LINE = BYTES_PER_LINE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       q_full,
    output logic       q_push,
    output hxf_cmd_t   q_cmd
);

    localparam logic [LINE_CNT_W-1:0] LINE_LIMIT = LINE_CNT_W'(BYTES_PER_LINE);

    logic [LINE_CNT_W-1:0] bytes_in_line_reg;
    logic [LINE_CNT_W-1:0] bytes_in_line_next;
    logic [LINE_CNT_W-1:0] count_inc;
    logic                  line_close;

    assign in_stall   = q_full;
    assign q_push     = in_valid && !q_full;
    assign count_inc  = bytes_in_line_reg + LINE_CNT_W'(1);
    assign line_close = last_byte || (count_inc >= LINE_LIMIT) || (count_inc == '0);

    always_comb
    begin
        q_cmd.data = data_byte;
        q_cmd.head = (bytes_in_line_reg == '0);
        q_cmd.tail = line_close;
        bytes_in_line_next = bytes_in_line_reg;
        if (q_push)
            bytes_in_line_next = line_close ? '0 : count_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bytes_in_line_reg <= '0;
        else
            bytes_in_line_reg <= bytes_in_line_next;
    end

endmodule

@@ sv/hxf_queue.sv @@
// Short command queue between the front end and the character serializer.
`timescale 1ns / 1ps

module hxf_queue
    import hxf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  hxf_cmd_t push_cmd,
    input  logic     pop,
    output logic     full,
    output logic     not_empty,
    output hxf_cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hxf_cmd_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

@@ sv/hxf_back.sv @@
// Back end: emits queued commands' characters, one per cycle unless stalled.
`timescale 1ns / 1ps

module hxf_back
    import hxf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_not_empty,
    input  hxf_cmd_t   q_cmd,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       run_end
);

    hxf_phase_t            phase_reg, phase_next, eff_phase;
    logic [HEAD_IDX_W-1:0] head_idx_reg, head_idx_next, eff_idx;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_char_reg, char_next;
    logic                  run_end_reg, final_next;
    logic                  load;

    assign load      = q_not_empty && (!out_valid_reg || !out_stall);
    assign q_pop     = load && final_next;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign run_end   = run_end_reg;

    always_comb
    begin
        if (phase_reg == PH_BEGIN)
        begin
            eff_phase = q_cmd.head ? PH_HEAD : PH_HI;
            eff_idx   = '0;
        end
        else
        begin
            eff_phase = phase_reg;
            eff_idx   = head_idx_reg;
        end

        char_next     = 8'h00;
        final_next    = 1'b0;
        phase_next    = phase_reg;
        head_idx_next = head_idx_reg;

        unique case (eff_phase)
            PH_HEAD:
            begin
                char_next = head_char(eff_idx);
                if (eff_idx == HEAD_IDX_W'(HEAD_LEN - 1))
                begin
                    phase_next    = PH_HI;
                    head_idx_next = '0;
                end
                else
                begin
                    phase_next    = PH_HEAD;
                    head_idx_next = eff_idx + HEAD_IDX_W'(1);
                end
            end
            PH_HI:
            begin
                char_next  = hex_char(q_cmd.data[7:4]);
                phase_next = PH_LO;
            end
            PH_LO:
            begin
                char_next  = hex_char(q_cmd.data[3:0]);
                final_next = !q_cmd.tail;
                phase_next = q_cmd.tail ? PH_CR : PH_BEGIN;
            end
            PH_CR:
            begin
                char_next  = CHAR_CR;
                phase_next = PH_LF;
            end
            PH_LF:
            begin
                char_next  = CHAR_LF;
                final_next = 1'b1;
                phase_next = PH_BEGIN;
            end
            PH_BEGIN:
            begin
                phase_next = PH_BEGIN;
            end
            default:
            begin
                phase_next = PH_BEGIN;
            end
        endcase

        if (!load)
        begin
            phase_next    = phase_reg;
            head_idx_next = head_idx_reg;
        end

        if (load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BEGIN;
            head_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            head_idx_reg  <= head_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= char_next;
            run_end_reg  <= final_next;
        end
    end

    a_run_end_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && run_end_reg |->
            (out_char_reg == CHAR_LF)
            || (out_char_reg >= 8'h30 && out_char_reg <= 8'h39)
            || (out_char_reg >= 8'h61 && out_char_reg <= 8'h66))
        else $error("run_end on a character that cannot close a byte");

    a_head_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEAD |-> head_idx_reg < HEAD_IDX_W'(HEAD_LEN))
        else $error("line head index out of range");

    a_pop_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_valid_reg && run_end_reg && phase_reg == PH_BEGIN)
        else $error("command retired without a closing character");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(phase_reg)
            && $stable(head_idx_reg))
        else $error("serializer advanced while output stalled");

endmodule

@@ sv/hex_ascii_line_framer.sv @@
// Top level of the hex ASCII line framer: front end, command queue, serializer.
`timescale 1ns / 1ps

//  beat       | ports                              | direction
//  -----------+------------------------------------+----------
//  input      | in_valid, in_stall, data_byte,     | in
//             | last_byte                          |
//  output     | out_valid, out_stall, out_char,    | out
//             | run_end                            |
//
//  One character leaves per cycle unless output stalls or the queue is empty; a byte
//  gives 2 hex digits, plus 5 for a line head, plus 2 for CR LF at a line end.
//  The serializer's one-character-per-cycle output register sets the sustained rate.
//  A byte is taken in the cycle it arrives while the queue has room.
//  Reset clears the line count, queue and output valid; no clearing pass.
//  Output stall holds the output register; input stall rises only when the queue fills.

module hex_ascii_line_framer
    import hxf_pkg::*;
#(
    parameter int BYTES_PER_LINE = BYTES_PER_LINE_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       run_end
);

    hxf_cmd_t push_cmd;
    hxf_cmd_t head_cmd;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_not_empty;

    hxf_front #(
        .BYTES_PER_LINE (BYTES_PER_LINE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    hxf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    hxf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .run_end     (run_end)
    );

endmodule
